/* design/mmes_pkg.sv */
// Shared types and constants for the MIDI meta event scanner.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps

package mmes_pkg;

    localparam logic [7:0]  META_PREFIX    = 8'hFF;
    localparam logic [7:0]  META_TEMPO     = 8'h51;
    localparam logic [7:0]  META_KEY       = 8'h59;
    localparam logic [7:0]  META_TIME_SIG  = 8'h58;

    localparam logic [7:0]  MAGIC_TAG [4]  = '{8'h4D, 8'h54, 8'h68, 8'h64}; // "MThd"

    localparam int          BPM_W          = 34;
    localparam int          US_W           = 24;
    localparam logic [BPM_W-1:0] BPM_Q8_NUMERATOR = 34'd15360000000;
    localparam logic [BPM_W-1:0] DEFAULT_BPM_Q8   = 34'd30720;
    localparam logic [15:0] DEFAULT_TICKS  = 16'd480;
    localparam logic [7:0]  DEFAULT_BEATS  = 8'd4;
    localparam logic [7:0]  DEFAULT_UNIT   = 8'd2;

    localparam logic [3:0]  CNT_MAX        = 4'd15;
    localparam logic [3:0]  TICKS_POS      = 4'd13;
    localparam logic [3:0]  TICKS_MIN_LEN  = 4'd14;
    localparam logic [3:0]  WIN_FULL       = 4'd6;
    localparam logic [3:0]  KEY_MIN_POS    = 4'd4;
    localparam logic [3:0]  HDR_LEN        = 4'd4;

    // one quotient bit per divide step
    localparam logic [5:0]  DIV_LAST_STEP  = 6'd33;

    typedef struct packed {
        logic capture;   // a byte request is accepted
        logic finish;    // the accepted byte is the last one
        logic div_step;  // advance the divider by one bit
    } t_cmd;

    typedef struct packed {
        logic need_div;  // last byte closes a file with a nonzero tempo
    } t_sts;

endpackage

/* design/midi_meta_event_scanner.sv */
// MIDI meta event scanner: one file byte per cycle while o_stall is low; no result until the last byte.
// Last byte with a nonzero tempo event: result valid once the 34 steps of the restoring
// BPM divider are done; otherwise valid on the next cycle.
// Input stalls from the last byte until the result request is taken.
// Synchronous active-low reset clears the scan window, counters and found flags.
`timescale 1ns / 1ps

module midi_meta_event_scanner
    import mmes_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [7:0]        i_data_byte,
    input  logic              i_end_of_file,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [33:0]       o_tempo_bpm_q8,
    output logic              o_tempo_zero_flag,
    output logic signed [7:0] o_key_sharps,
    output logic              o_key_minor,
    output logic [7:0]        o_beats_per_bar,
    output logic [7:0]        o_beat_unit_log2,
    output logic [15:0]       o_beat_ticks
);

    t_cmd cmd;
    t_sts sts;

    mmes_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_end_of_file (i_end_of_file),
        .i_stall       (i_stall),
        .i_sts         (sts),
        .o_cmd         (cmd),
        .o_stall       (o_stall),
        .o_valid       (o_valid)
    );

    mmes_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_data_byte       (i_data_byte),
        .o_sts             (sts),
        .o_tempo_bpm_q8    (o_tempo_bpm_q8),
        .o_tempo_zero_flag (o_tempo_zero_flag),
        .o_key_sharps      (o_key_sharps),
        .o_key_minor       (o_key_minor),
        .o_beats_per_bar   (o_beats_per_bar),
        .o_beat_unit_log2  (o_beat_unit_log2),
        .o_beat_ticks      (o_beat_ticks)
    );

endmodule

/* design/mmes_ctrl.sv */
// Controller for the MIDI meta event scanner: scan / divide / deliver sequencing.
// Depends on mmes_pkg.
`timescale 1ns / 1ps

module mmes_ctrl
    import mmes_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic i_end_of_file,
    input  logic i_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_stall,
    output logic o_valid
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0] r_state, n_state;
    logic [5:0] r_step, n_step;
    logic       accept;

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_DONE);
    assign accept  = i_valid && (r_state == S_IDLE);

    always_comb begin
        o_cmd.capture  = accept;
        o_cmd.finish   = accept && i_end_of_file;
        o_cmd.div_step = (r_state == S_DIV);
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_end_of_file) begin
                    if (i_sts.need_div) begin
                        n_state = S_DIV;
                        n_step  = DIV_LAST_STEP;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DIV: begin
                if (r_step == 6'd0) begin
                    n_state = S_DONE;
                end else begin
                    n_step = r_step - 6'd1;
                end
            end
            S_DONE: begin
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    a_short_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.finish && !i_sts.need_div) |=> (r_state == S_DONE))
        else $error("finish without divide did not go to result");

    a_div_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.finish && i_sts.need_div) |=> ##33 (r_state == S_DIV && r_step == 6'd0))
        else $error("divide step count wrong");

    a_div_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_step == 6'd0) |=> (r_state == S_DONE))
        else $error("divider did not hand over to result");

    a_no_capture_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_step |-> !o_cmd.capture)
        else $error("byte captured during divide");

endmodule

/* design/mmes_datapath.sv */
// Datapath for the MIDI meta event scanner: byte window, event capture,
// result snapshot and restoring divider for the BPM value. Depends on mmes_pkg.
`timescale 1ns / 1ps

module mmes_datapath
    import mmes_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic [7:0]        i_data_byte,
    output t_sts              o_sts,
    output logic [BPM_W-1:0]  o_tempo_bpm_q8,
    output logic              o_tempo_zero_flag,
    output logic signed [7:0] o_key_sharps,
    output logic              o_key_minor,
    output logic [7:0]        o_beats_per_bar,
    output logic [7:0]        o_beat_unit_log2,
    output logic [15:0]       o_beat_ticks
);

    // scan state
    logic [7:0]      r_win [6];
    logic [3:0]      r_cnt;
    logic            r_hdr;
    logic            r_tfound;
    logic [US_W-1:0] r_tus;
    logic            r_kfound;
    logic [8:0]      r_kval;
    logic            r_sfound;
    logic [15:0]     r_sval;
    logic [15:0]     r_ticks;

    logic [3:0]      n_cnt;
    logic            n_hdr;
    logic            n_tfound;
    logic [US_W-1:0] n_tus;
    logic            n_kfound;
    logic [8:0]      n_kval;
    logic            n_sfound;
    logic [15:0]     n_sval;
    logic [15:0]     n_ticks;

    // result snapshot
    logic            r_res_tfound;
    logic            r_res_tzero;
    logic [8:0]      r_res_key;
    logic [15:0]     r_res_sig;
    logic [15:0]     r_res_ticks;

    // divider
    logic [BPM_W-1:0] r_dvd;
    logic [US_W-1:0]  r_div;
    logic [US_W-1:0]  r_rem;
    logic [US_W:0]    rem_sh;
    logic [US_W:0]    rem_dif;
    logic             q_bit;

    always_comb begin
        n_cnt    = (r_cnt == CNT_MAX) ? r_cnt : r_cnt + 4'd1;
        n_hdr    = r_hdr;
        n_tfound = r_tfound;
        n_tus    = r_tus;
        n_kfound = r_kfound;
        n_kval   = r_kval;
        n_sfound = r_sfound;
        n_sval   = r_sval;
        n_ticks  = r_ticks;

        if (r_cnt < HDR_LEN && i_data_byte != MAGIC_TAG[r_cnt[1:0]]) begin
            n_hdr = 1'b0;
        end
        if (r_cnt == TICKS_POS) begin
            n_ticks = {r_win[5], i_data_byte};
        end
        if (r_cnt >= WIN_FULL) begin
            if (!r_tfound && r_win[0] == META_PREFIX && r_win[1] == META_TEMPO) begin
                n_tfound = 1'b1;
                n_tus    = {r_win[3], r_win[4], r_win[5]};
            end
            if (!r_sfound && r_win[0] == META_PREFIX && r_win[1] == META_TIME_SIG) begin
                n_sfound = 1'b1;
                n_sval   = {r_win[4], r_win[3]};
            end
        end
        // key event needs only the sf byte and the mode byte (current)
        if (r_cnt >= KEY_MIN_POS && !r_kfound && r_win[2] == META_PREFIX
                && r_win[3] == META_KEY) begin
            n_kfound = 1'b1;
            n_kval   = {(i_data_byte != 8'd0), r_win[5]};
        end
    end

    assign o_sts.need_div = n_tfound && (n_tus != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 6; k++) begin
                r_win[k] <= '0;
            end
            r_cnt    <= '0;
            r_hdr    <= 1'b1;
            r_tfound <= 1'b0;
            r_tus    <= '0;
            r_kfound <= 1'b0;
            r_kval   <= '0;
            r_sfound <= 1'b0;
            r_sval   <= '0;
            r_ticks  <= '0;
        end else if (i_cmd.capture) begin
            if (i_cmd.finish) begin
                for (int k = 0; k < 6; k++) begin
                    r_win[k] <= '0;
                end
                r_cnt    <= '0;
                r_hdr    <= 1'b1;
                r_tfound <= 1'b0;
                r_tus    <= '0;
                r_kfound <= 1'b0;
                r_kval   <= '0;
                r_sfound <= 1'b0;
                r_sval   <= '0;
                r_ticks  <= '0;
            end else begin
                for (int k = 0; k < 5; k++) begin
                    r_win[k] <= r_win[k+1];
                end
                r_win[5] <= i_data_byte;
                r_cnt    <= n_cnt;
                r_hdr    <= n_hdr;
                r_tfound <= n_tfound;
                r_tus    <= n_tus;
                r_kfound <= n_kfound;
                r_kval   <= n_kval;
                r_sfound <= n_sfound;
                r_sval   <= n_sval;
                r_ticks  <= n_ticks;
            end
        end
    end

    // snapshot with defaults applied
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_res_tfound <= n_tfound;
            r_res_tzero  <= (n_tus == '0);
            r_res_key    <= n_kfound ? n_kval : 9'd0;
            r_res_sig    <= n_sfound ? n_sval : {DEFAULT_UNIT, DEFAULT_BEATS};
            r_res_ticks  <= (n_hdr && n_cnt >= TICKS_MIN_LEN) ? n_ticks : DEFAULT_TICKS;
        end
    end

    // restoring division, one quotient bit per step; quotient shifts into r_dvd
    assign rem_sh  = {r_rem, r_dvd[BPM_W-1]};
    assign rem_dif = rem_sh - {1'b0, r_div};
    assign q_bit   = (rem_sh >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_dvd <= BPM_Q8_NUMERATOR + {{(BPM_W-US_W+1){1'b0}}, n_tus[US_W-1:1]};
            r_div <= n_tus;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[BPM_W-2:0], q_bit};
            r_rem <= q_bit ? rem_dif[US_W-1:0] : rem_sh[US_W-1:0];
        end
    end

    always_comb begin
        if (!r_res_tfound) begin
            o_tempo_bpm_q8    = DEFAULT_BPM_Q8;
            o_tempo_zero_flag = 1'b0;
        end else if (r_res_tzero) begin
            o_tempo_bpm_q8    = BPM_Q8_NUMERATOR;
            o_tempo_zero_flag = 1'b1;
        end else begin
            o_tempo_bpm_q8    = r_dvd;
            o_tempo_zero_flag = 1'b0;
        end
    end

    assign o_key_sharps     = signed'(r_res_key[7:0]);
    assign o_key_minor      = r_res_key[8];
    assign o_beats_per_bar  = r_res_sig[7:0];
    assign o_beat_unit_log2 = r_res_sig[15:8];
    assign o_beat_ticks     = r_res_ticks;

endmodule

/* test/tb_top.sv */
// Self-checking bench for midi_meta_event_scanner: byte streams of MIDI files in, summaries out.
// Holds its own scan predictor; depends on mmes_pkg and the scanner RTL only.
`timescale 1ns / 1ps

module tb_top;
    import mmes_pkg::*;

    typedef struct packed {
        logic [33:0] bpm_q8;
        logic        zero_flag;
        logic [7:0]  sharps;
        logic        minor;
        logic [7:0]  beats;
        logic [7:0]  beat_unit;
        logic [15:0] ticks;
    } t_meta_summary;

    typedef struct packed {
        logic [7:0]    data;
        logic          last;
        logic          typed;
        t_meta_summary want;
    } t_scan_row;

    localparam t_meta_summary NO_SUMMARY = '0;
    localparam t_meta_summary SUM_DEFAULTS = '{DEFAULT_BPM_Q8, 1'b0, 8'h00, 1'b0,
                                              DEFAULT_BEATS, DEFAULT_UNIT, DEFAULT_TICKS};
    localparam t_meta_summary SUM_HEADER = '{DEFAULT_BPM_Q8, 1'b0, 8'h00, 1'b0,
                                            8'hFF, 8'hFF, 16'hFFFF};
    localparam t_meta_summary SUM_ZERO_KEY = '{BPM_Q8_NUMERATOR, 1'b1, 8'h80, 1'b1,
                                              DEFAULT_BEATS, DEFAULT_UNIT, DEFAULT_TICKS};

    localparam int N_DIRECTED  = 26;
    localparam int TOTAL_ITEMS = N_DIRECTED + 1050;
    localparam int CYCLE_LIMIT = 500000;
    localparam int LONG_HOLD   = 300;

    // one-byte file; full header with a time signature and max division;
    // zero tempo followed by an out-of-range minor key
    localparam t_scan_row DIRECTED [N_DIRECTED] = '{
        '{8'h00, 1'b1, 1'b1, SUM_DEFAULTS},
        '{8'h4D, 1'b0, 1'b0, NO_SUMMARY},
        '{8'h54, 1'b0, 1'b0, NO_SUMMARY},
        '{8'h68, 1'b0, 1'b0, NO_SUMMARY},
        '{8'h64, 1'b0, 1'b0, NO_SUMMARY},
        '{8'hFF, 1'b0, 1'b0, NO_SUMMARY},
        '{8'h58, 1'b0, 1'b0, NO_SUMMARY},
        '{8'h04, 1'b0, 1'b0, NO_SUMMARY},
        '{8'hFF, 1'b0, 1'b0, NO_SUMMARY},
        '{8'hFF, 1'b0, 1'b0, NO_SUMMARY},
        '{8'h00, 1'b0, 1'b0, NO_SUMMARY},
        '{8'h00, 1'b0, 1'b0, NO_SUMMARY},
        '{8'h00, 1'b0, 1'b0, NO_SUMMARY},
        '{8'hFF, 1'b0, 1'b0, NO_SUMMARY},
        '{8'hFF, 1'b1, 1'b1, SUM_HEADER},
        '{8'hFF, 1'b0, 1'b0, NO_SUMMARY},
        '{8'h51, 1'b0, 1'b0, NO_SUMMARY},
        '{8'h03, 1'b0, 1'b0, NO_SUMMARY},
        '{8'h00, 1'b0, 1'b0, NO_SUMMARY},
        '{8'h00, 1'b0, 1'b0, NO_SUMMARY},
        '{8'h00, 1'b0, 1'b0, NO_SUMMARY},
        '{8'hFF, 1'b0, 1'b0, NO_SUMMARY},
        '{8'h59, 1'b0, 1'b0, NO_SUMMARY},
        '{8'h02, 1'b0, 1'b0, NO_SUMMARY},
        '{8'h80, 1'b0, 1'b0, NO_SUMMARY},
        '{8'h01, 1'b1, 1'b1, SUM_ZERO_KEY}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_end_of_file = 1'b0;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [33:0] o_tempo_bpm_q8;
    logic        o_tempo_zero_flag;
    logic [7:0]  o_key_sharps;
    logic        o_key_minor;
    logic [7:0]  o_beats_per_bar;
    logic [7:0]  o_beat_unit_log2;
    logic [15:0] o_beat_ticks;

    midi_meta_event_scanner DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_data_byte       (i_data_byte),
        .i_end_of_file     (i_end_of_file),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_tempo_bpm_q8    (o_tempo_bpm_q8),
        .o_tempo_zero_flag (o_tempo_zero_flag),
        .o_key_sharps      (o_key_sharps),
        .o_key_minor       (o_key_minor),
        .o_beats_per_bar   (o_beats_per_bar),
        .o_beat_unit_log2  (o_beat_unit_log2),
        .o_beat_ticks      (o_beat_ticks)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("tb: failure");
        $finish;
    end

    // ---------------- scan predictor ----------------
    logic [7:0]  win [6];
    logic [3:0]  seen;
    logic        hdr_ok, tempo_hit, key_hit, sig_hit;
    logic [23:0] tempo_us;
    logic [7:0]  sharps_q, beats_q, beat_unit_q;
    logic        minor_q;
    logic [15:0] ticks_q;

    t_meta_summary pending_summaries [$];
    int          items_sent = 0;
    int          mismatches = 0;
    logic        calm = 1'b0;

    task automatic clear_scan();
        int k;
        for (k = 0; k < 6; k++) win[k] = 8'h00;
        seen = '0;
        hdr_ok = 1'b1;
        tempo_hit = 1'b0;
        tempo_us = '0;
        key_hit = 1'b0;
        sharps_q = '0;
        minor_q = 1'b0;
        sig_hit = 1'b0;
        beats_q = '0;
        beat_unit_q = '0;
        ticks_q = '0;
    endtask

    task automatic predict_scan(input logic [7:0] b, input logic last,
                                output logic produced, output t_meta_summary sum);
        logic [63:0] us_wide, quot;
        int k;
        produced = 1'b0;
        sum = '0;
        if (seen < HDR_LEN && b != MAGIC_TAG[seen[1:0]]) hdr_ok = 1'b0;
        if (seen == TICKS_POS) ticks_q = {win[5], b};
        // tempo / time signature need the whole event in the window
        if (seen >= WIN_FULL) begin
            if (!tempo_hit && win[0] == META_PREFIX && win[1] == META_TEMPO) begin
                tempo_hit = 1'b1;
                tempo_us = {win[3], win[4], win[5]};
            end
            if (!sig_hit && win[0] == META_PREFIX && win[1] == META_TIME_SIG) begin
                sig_hit = 1'b1;
                beats_q = win[3];
                beat_unit_q = win[4];
            end
        end
        if (seen >= KEY_MIN_POS && !key_hit && win[2] == META_PREFIX && win[3] == META_KEY) begin
            key_hit = 1'b1;
            sharps_q = win[5];
            minor_q = (b != 8'h00);
        end
        for (k = 0; k < 5; k++) win[k] = win[k + 1];
        win[5] = b;
        if (seen != CNT_MAX) seen = seen + 1'b1;

        if (last) begin
            produced = 1'b1;
            if (!tempo_hit) begin
                sum.bpm_q8 = DEFAULT_BPM_Q8;
            end else if (tempo_us == '0) begin
                sum.bpm_q8 = BPM_Q8_NUMERATOR;
                sum.zero_flag = 1'b1;
            end else begin
                us_wide = {40'd0, tempo_us};
                quot = ({30'd0, BPM_Q8_NUMERATOR} + us_wide / 2) / us_wide;
                sum.bpm_q8 = quot[33:0];
            end
            sum.sharps = key_hit ? sharps_q : 8'h00;
            sum.minor = key_hit ? minor_q : 1'b0;
            sum.beats = sig_hit ? beats_q : DEFAULT_BEATS;
            sum.beat_unit = sig_hit ? beat_unit_q : DEFAULT_UNIT;
            sum.ticks = (hdr_ok && seen >= TICKS_MIN_LEN) ? ticks_q : DEFAULT_TICKS;
            clear_scan();
        end
    endtask

    // ---------------- byte requests ----------------
    task automatic send_byte(input logic [7:0] b, input logic last,
                             input logic typed, input t_meta_summary typed_sum);
        t_meta_summary predicted;
        logic produced;
        if (!calm && $urandom_range(0, 9) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data_byte <= b;
        i_end_of_file <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_scan(b, last, produced, predicted);
        if (produced) pending_summaries.push_back(typed ? typed_sum : predicted);
        items_sent++;
    endtask

    // Mostly well-formed files: optional MThd header, then meta events with random
    // content and noise; some files are cut short to hit the end-of-data limits.
    task automatic build_file(output logic [7:0] fb [$]);
        int n_chunks, kind, v, k;
        logic [23:0] tus;
        fb = {};
        if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 3)) fb.push_back(8'($urandom));
            return;
        end
        if ($urandom_range(0, 1) == 1) begin
            for (k = 0; k < 4; k++) fb.push_back(MAGIC_TAG[k]);
            if ($urandom_range(0, 5) == 0) fb[$urandom_range(0, 3)] = 8'($urandom);
            repeat (10) fb.push_back(8'($urandom));
        end
        n_chunks = $urandom_range(0, 4);
        repeat (n_chunks) begin
            kind = $urandom_range(0, 4);
            case (kind)
                0: begin
                    v = $urandom_range(0, 7);
                    tus = (v == 0) ? 24'd0 : (v == 1) ? 24'd1 : (v == 2) ? 24'hFFFFFF
                        : 24'($urandom_range(1, 24'hFFFFFF));
                    fb.push_back(META_PREFIX);
                    fb.push_back(META_TEMPO);
                    fb.push_back(8'h03);
                    fb.push_back(tus[23:16]);
                    fb.push_back(tus[15:8]);
                    fb.push_back(tus[7:0]);
                end
                1: begin
                    v = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 14) - 7 : $urandom;
                    fb.push_back(META_PREFIX);
                    fb.push_back(META_KEY);
                    fb.push_back(8'h02);
                    fb.push_back(v[7:0]);
                    fb.push_back(($urandom_range(0, 2) == 0) ? 8'($urandom)
                                                             : 8'($urandom_range(0, 1)));
                end
                2: begin
                    fb.push_back(META_PREFIX);
                    fb.push_back(META_TIME_SIG);
                    fb.push_back(8'h04);
                    repeat (4) fb.push_back(8'($urandom));
                end
                3: begin
                    repeat ($urandom_range(0, 4)) fb.push_back(8'($urandom));
                end
                default: begin
                    // near miss: prefix and tag with no room for the rest
                    fb.push_back(META_PREFIX);
                    v = $urandom_range(0, 3);
                    fb.push_back((v == 0) ? META_TEMPO : (v == 1) ? META_KEY
                                 : (v == 2) ? META_TIME_SIG : 8'($urandom));
                    repeat ($urandom_range(0, 3)) fb.push_back(8'($urandom));
                end
            endcase
        end
        repeat ($urandom_range(0, 3)) fb.push_back(8'($urandom));
        if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 3)) if (fb.size() > 1) void'(fb.pop_back());
        end
        if (fb.size() == 0) fb.push_back(8'($urandom));
    endtask

    initial begin
        logic [7:0] file_bytes [$];
        int r, files_done;
        clear_scan();
        files_done = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (r = 0; r < N_DIRECTED; r++)
            send_byte(DIRECTED[r].data, DIRECTED[r].last, DIRECTED[r].typed, DIRECTED[r].want);

        while (items_sent < TOTAL_ITEMS) begin
            build_file(file_bytes);
            for (r = 0; r < file_bytes.size(); r++)
                send_byte(file_bytes[r], r == file_bytes.size() - 1, 1'b0, NO_SUMMARY);
            files_done++;
            if (files_done == 12) begin
                // drain everything before the next file
                i_valid <= 1'b0;
                do @(posedge i_clk); while (pending_summaries.size() != 0);
            end
            if (!calm && items_sent > TOTAL_ITEMS - 150) calm <= 1'b1;
        end

        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_summaries.size() != 0);
        repeat (40) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // ---------------- result checking ----------------
    task automatic compare_field(input string label, input logic [33:0] want,
                                 input logic [33:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s expected %0d actual %0d", $time, label, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_meta_summary want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_summaries.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none actual bpm %0d ticks %0d",
                         $time, o_tempo_bpm_q8, o_beat_ticks);
            end else begin
                want = pending_summaries.pop_front();
                compare_field("tempo_bpm_q8", want.bpm_q8, o_tempo_bpm_q8);
                compare_field("tempo_zero_flag", 34'(want.zero_flag), 34'(o_tempo_zero_flag));
                compare_field("key_sharps", 34'(want.sharps), 34'(o_key_sharps));
                compare_field("key_minor", 34'(want.minor), 34'(o_key_minor));
                compare_field("beats_per_bar", 34'(want.beats), 34'(o_beats_per_bar));
                compare_field("beat_unit_log2", 34'(want.beat_unit), 34'(o_beat_unit_log2));
                compare_field("beat_ticks", 34'(want.ticks), 34'(o_beat_ticks));
            end
        end
    end

    // ---------------- output stall ----------------
    int results_taken = 0;
    int stall_left = 0;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            results_taken++;
            // long hold-off so the scanner backs up onto its input
            if (results_taken == 4) stall_left = LONG_HOLD;
        end

        if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            i_stall <= 1'b1;
            stall_left = $urandom_range(1, 17) - 1;
        end else begin
            i_stall <= 1'b0;
        end
    end

endmodule

/* midi_meta_event_scanner.f */
design/mmes_pkg.sv
design/mmes_ctrl.sv
design/mmes_datapath.sv
design/midi_meta_event_scanner.sv
test/tb_top.sv
